// ===== rtl/core/mdio22_pkg.sv =====
`default_nettype none

package mdio22_pkg;

    localparam int MAX_PREAMBLE_DEF = 32;
    localparam int FRAME_BITS       = 32;
    localparam int ACK_BIT          = 15;
    localparam int ADDR_W           = 5;
    localparam int DATA_W           = 16;
    localparam int PRE_W            = 6;
    localparam int CFG_IDX_W        = 1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_mdio22_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREAMBLE   = 1'b0,
        CFG_READ_SHIFT = 1'b1
    } t_mdio22_cfg;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] phy_address;
        logic [ADDR_W-1:0] register_address;
        logic [DATA_W-1:0] write_data;
        logic              mdio_in;
    } t_mdio22_req;

    typedef struct packed {
        logic              mdc;
        logic              mdio_pull_low;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] read_data;
        logic              no_ack;
    } t_mdio22_res;

endpackage

`default_nettype wire

// ===== rtl/core/mdio22_req_if.sv =====
`default_nettype none

interface mdio22_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [4:0]  phy_address;
    logic [4:0]  register_address;
    logic [15:0] write_data;
    logic        mdio_in;

    modport source (
        output valid, operation, phy_address, register_address, write_data, mdio_in,
        input  ready
    );
    modport sink (
        input  valid, operation, phy_address, register_address, write_data, mdio_in,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/mdio22_rsp_if.sv =====
`default_nettype none

interface mdio22_rsp_if;
    logic        valid;
    logic        ready;
    logic        mdc;
    logic        mdio_pull_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        no_ack;

    modport source (
        output valid, mdc, mdio_pull_low, busy_res, done_res, read_data, no_ack,
        input  ready
    );
    modport sink (
        input  valid, mdc, mdio_pull_low, busy_res, done_res, read_data, no_ack,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/mdio22_frame_engine.sv =====
`default_nettype none

module mdio22_frame_engine
    import mdio22_pkg::*;
#(
    parameter int MAX_PREAMBLE = MAX_PREAMBLE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire t_mdio22_req       i_req,
    input  wire logic [PRE_W-1:0]  i_preamble_bits,
    input  wire logic              i_read_shift,
    output t_mdio22_res            o_res
);

    localparam int END_TICK = 2 * (MAX_PREAMBLE + FRAME_BITS);
    localparam int TICK_W   = $clog2(END_TICK + 1);
    localparam int B_W      = TICK_W - 1;
    localparam int K_W      = $clog2(FRAME_BITS);

    logic [TICK_W-1:0]     r_tick,    n_tick;
    logic [FRAME_BITS-1:0] r_send,    n_send;
    logic [DATA_W-1:0]     r_cap,     n_cap;
    logic                  r_reading, n_reading;
    logic                  r_ack,     n_ack;
    logic                  r_active,  n_active;
    logic [DATA_W-1:0]     r_rdata,   n_rdata;
    logic                  r_noack,   n_noack;

    logic                  start;
    logic                  wr;
    logic [TICK_W-1:0]     pre_ext;
    logic [TICK_W-1:0]     pre_sat;
    logic [TICK_W-1:0]     t;
    logic [B_W-1:0]        b;
    logic [K_W-1:0]        k;
    logic                  bit_out;

    always_comb begin
        start   = !r_active && (i_req.operation == OP_READ || i_req.operation == OP_WRITE);
        wr      = (i_req.operation == OP_WRITE);
        pre_ext = TICK_W'(i_preamble_bits);
        pre_sat = (pre_ext > TICK_W'(MAX_PREAMBLE)) ? TICK_W'(MAX_PREAMBLE) : pre_ext;

        n_tick    = r_tick;
        n_send    = r_send;
        n_cap     = r_cap;
        n_reading = r_reading;
        n_ack     = r_ack;
        n_active  = r_active;
        n_rdata   = r_rdata;
        n_noack   = r_noack;

        o_res = '0;

        // new frame: load header and position from the preamble length
        if (start) begin
            n_reading = !wr;
            n_send    = {1'b0, 1'b1, (wr ? 2'b01 : 2'b10), i_req.phy_address,
                         i_req.register_address, (wr ? 2'b10 : 2'b11),
                         (wr ? i_req.write_data : {DATA_W{1'b1}})};
            n_tick    = TICK_W'(2 * MAX_PREAMBLE) - (pre_sat << 1);
            n_cap     = '0;
            n_ack     = 1'b0;
            n_active  = 1'b1;
        end

        t       = n_tick;
        b       = t[TICK_W-1:1];
        k       = K_W'(b - B_W'(MAX_PREAMBLE));
        bit_out = 1'b1;

        if (n_active) begin
            if (t >= TICK_W'(END_TICK)) begin
                if (n_reading) begin
                    if (n_ack) begin
                        n_rdata = i_read_shift ? (n_cap >> 1) : n_cap;
                        n_noack = 1'b0;
                    end else begin
                        n_noack = 1'b1;
                    end
                end
                o_res.done_res = 1'b1;
                n_active       = 1'b0;
                n_tick         = '0;
            end else begin
                if (b >= B_W'(MAX_PREAMBLE)) begin
                    bit_out = n_send[K_W'(FRAME_BITS - 1) - k];
                    if (n_reading && t[0]) begin
                        if (k == K_W'(ACK_BIT)) begin
                            n_ack = !i_req.mdio_in;
                        end else if (k > K_W'(ACK_BIT)) begin
                            n_cap = {n_cap[DATA_W-2:0], i_req.mdio_in};
                        end
                    end
                end
                o_res.mdc           = t[0];
                o_res.mdio_pull_low = !bit_out;
                o_res.busy_res      = 1'b1;
                n_tick              = t + 1'b1;
            end
        end

        o_res.read_data = n_rdata;
        o_res.no_ack    = n_noack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_send    <= '0;
            r_cap     <= '0;
            r_reading <= 1'b0;
            r_ack     <= 1'b0;
            r_active  <= 1'b0;
            r_rdata   <= '0;
            r_noack   <= 1'b0;
        end else if (i_step) begin
            r_tick    <= n_tick;
            r_send    <= n_send;
            r_cap     <= n_cap;
            r_reading <= n_reading;
            r_ack     <= n_ack;
            r_active  <= n_active;
            r_rdata   <= n_rdata;
            r_noack   <= n_noack;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mdio22_out_stage.sv =====
`default_nettype none

module mdio22_out_stage
    import mdio22_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire t_mdio22_res i_res,
    input  wire logic        i_ready,
    output logic             o_free,
    output logic             o_valid,
    output t_mdio22_res      o_res
);

    logic        r_valid;
    t_mdio22_res r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mdio_clause22_frame_master.sv =====
// Clause 22 MDIO frame master. Each request is one half-period tick of the
// management clock and produces exactly one result: the mdc level, whether to
// pull the open-drain data line low, busy and done flags, and the stored data
// and no-acknowledge flag of the last finished read. A read or write request
// is taken only while idle. A request is taken every cycle; its result is
// computed combinationally and registered in the output stage, and the only thing that
// holds requests back is a full output register that the sink has not taken.
// Preamble length and read data shift are set through the write port; the
// preamble length is sampled at the start of each frame and the read data
// shift on the tick that finishes a read.
`default_nettype none

module mdio_clause22_frame_master
    import mdio22_pkg::*;
#(
    parameter int MAX_PREAMBLE = MAX_PREAMBLE_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [PRE_W-1:0]     i_cfg_data,
    mdio22_req_if.sink                i_req,
    mdio22_rsp_if.source              o_rsp
);

    logic [PRE_W-1:0] r_preamble_bits;
    logic             r_read_shift;
    logic             free;
    logic             step;
    logic             out_valid;
    t_mdio22_req      req;
    t_mdio22_res      res;
    t_mdio22_res      out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble_bits <= PRE_W'(32);
            r_read_shift    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_mdio22_cfg'(i_cfg_idx))
                CFG_PREAMBLE:   r_preamble_bits <= i_cfg_data;
                CFG_READ_SHIFT: r_read_shift    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign req.operation        = i_req.operation;
    assign req.phy_address      = i_req.phy_address;
    assign req.register_address = i_req.register_address;
    assign req.write_data       = i_req.write_data;
    assign req.mdio_in          = i_req.mdio_in;

    assign i_req.ready = free;
    assign step        = i_req.valid && free;

    mdio22_frame_engine #(
        .MAX_PREAMBLE (MAX_PREAMBLE)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_req           (req),
        .i_preamble_bits (r_preamble_bits),
        .i_read_shift    (r_read_shift),
        .o_res           (res)
    );

    mdio22_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (res),
        .i_ready (o_rsp.ready),
        .o_free  (free),
        .o_valid (out_valid),
        .o_res   (out_res)
    );

    assign o_rsp.valid         = out_valid;
    assign o_rsp.mdc           = out_res.mdc;
    assign o_rsp.mdio_pull_low = out_res.mdio_pull_low;
    assign o_rsp.busy_res      = out_res.busy_res;
    assign o_rsp.done_res      = out_res.done_res;
    assign o_rsp.read_data     = out_res.read_data;
    assign o_rsp.no_ack        = out_res.no_ack;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !(out_res.done_res && out_res.busy_res))
        else $error("done and busy together");

    a_mdc_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_res.mdc |-> out_res.busy_res)
        else $error("mdc high outside a frame");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> out_valid)
        else $error("accepted request gave no result");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mdio22_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'b11;
    localparam int END_TICK = 2 * (MAX_PREAMBLE_DEF + FRAME_BITS);

    class mdio_line_tracker;
        logic [5:0]  preamble_len = 6'd32;
        logic        read_shift = 1'b1;
        logic [7:0]  tick_index = '0;
        logic [31:0] frame_bits = '0;
        logic [15:0] capture = '0;
        bit          reading = 1'b0;
        bit          ack_seen = 1'b0;
        bit          active = 1'b0;
        logic [15:0] read_value = '0;
        bit          read_failed = 1'b0;
        t_mdio22_res pending_lines[$];
        int unsigned mismatches = 0;

        function void load_register(t_mdio22_cfg idx, logic [5:0] value);
            if (idx == CFG_PREAMBLE) begin
                preamble_len = value;
            end else begin
                read_shift = value[0];
            end
        endfunction

        // one request is one half-period of mdc
        function void take_tick(t_mdio22_req r);
            logic [5:0]  pre;
            logic [7:0]  t;
            int          k;
            logic        send_bit;
            t_mdio22_res line;
            line = '0;
            if (!active && (r.operation == OP_READ || r.operation == OP_WRITE)) begin
                pre = (preamble_len > MAX_PREAMBLE_DEF) ? 6'(MAX_PREAMBLE_DEF) : preamble_len;
                reading = (r.operation == OP_READ);
                frame_bits = {2'b01, reading ? 2'b10 : 2'b01, r.phy_address,
                              r.register_address, reading ? 2'b11 : 2'b10,
                              reading ? 16'hFFFF : r.write_data};
                tick_index = 8'(2 * (MAX_PREAMBLE_DEF - int'(pre)));
                capture = '0;
                ack_seen = 1'b0;
                active = 1'b1;
            end
            if (active) begin
                t = tick_index;
                if (t >= END_TICK) begin
                    if (reading) begin
                        if (ack_seen) begin
                            read_value = read_shift ? (capture >> 1) : capture;
                            read_failed = 1'b0;
                        end else begin
                            read_failed = 1'b1;
                        end
                    end
                    line.done_res = 1'b1;
                    active = 1'b0;
                    tick_index = '0;
                end else begin
                    send_bit = 1'b1;
                    if (int'(t[7:1]) >= MAX_PREAMBLE_DEF) begin
                        k = int'(t[7:1]) - MAX_PREAMBLE_DEF;
                        send_bit = frame_bits[31 - k];
                        if (reading && t[0]) begin
                            if (k == ACK_BIT) begin
                                ack_seen = !r.mdio_in;
                            end else if (k > ACK_BIT) begin
                                capture = {capture[14:0], r.mdio_in};
                            end
                        end
                    end
                    line.mdc = t[0];
                    line.mdio_pull_low = !send_bit;
                    line.busy_res = 1'b1;
                    tick_index = t + 8'd1;
                end
            end
            line.read_data = read_value;
            line.no_ack = read_failed;
            pending_lines.push_back(line);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s expected %h got %h", $time, field, want, got);
            end
        endfunction

        function void check_line(t_mdio22_res got);
            t_mdio22_res want;
            if (pending_lines.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, read_data %h", $time, got.read_data);
            end else begin
                want = pending_lines.pop_front();
                compare_field("mdc", 16'(want.mdc), 16'(got.mdc));
                compare_field("mdio_pull_low", 16'(want.mdio_pull_low), 16'(got.mdio_pull_low));
                compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
                compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
                compare_field("read_data", want.read_data, got.read_data);
                compare_field("no_ack", 16'(want.no_ack), 16'(got.no_ack));
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [PRE_W-1:0]     i_cfg_data;
    bit                   no_idle = 1'b0;
    int                   items_sent = 0;

    mdio_line_tracker tracker = new;

    mdio22_req_if req_ch();
    mdio22_rsp_if rsp_ch();

    mdio_clause22_frame_master dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin : take_request
        t_mdio22_req r;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            r.operation = req_ch.operation;
            r.phy_address = req_ch.phy_address;
            r.register_address = req_ch.register_address;
            r.write_data = req_ch.write_data;
            r.mdio_in = req_ch.mdio_in;
            tracker.take_tick(r);
        end
    end

    always @(posedge i_clk) begin : take_result
        t_mdio22_res got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.mdc = rsp_ch.mdc;
            got.mdio_pull_low = rsp_ch.mdio_pull_low;
            got.busy_res = rsp_ch.busy_res;
            got.done_res = rsp_ch.done_res;
            got.read_data = rsp_ch.read_data;
            got.no_ack = rsp_ch.no_ack;
            tracker.check_line(got);
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
            @(negedge i_clk);
        end
    end

    task automatic push_tick(input t_mdio22_req item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= item.operation;
        req_ch.phy_address <= item.phy_address;
        req_ch.register_address <= item.register_address;
        req_ch.write_data <= item.write_data;
        req_ch.mdio_in <= item.mdio_in;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (tracker.pending_lines.size() != 0);
    endtask

    task automatic write_register(input t_mdio22_cfg idx, input logic [5:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        tracker.load_register(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic idle_ticks(input int count);
        t_mdio22_req r;
        repeat (count) begin
            r.operation = $urandom_range(0, 1) ? OP_TICK : OP_UNUSED;
            r.phy_address = 5'($urandom_range(0, 31));
            r.register_address = 5'($urandom_range(0, 31));
            r.write_data = 16'($urandom_range(0, 65535));
            r.mdio_in = 1'($urandom_range(0, 1));
            push_tick(r);
        end
    endtask

    // a whole frame: the request, then one tick per half period up to the done tick;
    // stray requests while busy are ignored, and with stray set the done tick carries one
    task automatic run_frame(input logic [1:0] op, input logic [4:0] phy,
                             input logic [4:0] reg_addr, input logic [15:0] wdata,
                             input bit acked, input logic [15:0] reply, input bit stray);
        t_mdio22_req r;
        int          pre;
        int          ticks;
        int          t;
        int          k;
        pre = (tracker.preamble_len > MAX_PREAMBLE_DEF) ? MAX_PREAMBLE_DEF
                                                         : int'(tracker.preamble_len);
        ticks = 2 * (pre + FRAME_BITS) + 1;
        for (int j = 0; j < ticks; j++) begin
            t = 2 * (MAX_PREAMBLE_DEF - pre) + j;
            if (j == 0) begin
                r.operation = op;
                r.phy_address = phy;
                r.register_address = reg_addr;
                r.write_data = wdata;
            end else begin
                r.operation = OP_TICK;
                if (stray) begin
                    r.operation = 2'($urandom_range(0, 3));
                end
                if (stray && j == ticks - 1) begin
                    r.operation = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
                end
                r.phy_address = 5'($urandom_range(0, 31));
                r.register_address = 5'($urandom_range(0, 31));
                r.write_data = 16'($urandom_range(0, 65535));
            end
            r.mdio_in = 1'($urandom_range(0, 1));
            if (op == OP_READ && (t % 2) == 1 && t / 2 >= MAX_PREAMBLE_DEF) begin
                k = t / 2 - MAX_PREAMBLE_DEF;
                if (k == ACK_BIT) begin
                    r.mdio_in = !acked;
                end else if (k > ACK_BIT) begin
                    r.mdio_in = reply[31 - k];
                end
            end
            push_tick(r);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_PREAMBLE;
        i_cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.operation <= OP_TICK;
        req_ch.phy_address <= '0;
        req_ch.register_address <= '0;
        req_ch.write_data <= '0;
        req_ch.mdio_in <= 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default preamble and shifted read data
        idle_ticks(3);
        run_frame(OP_READ, 5'd0, 5'd31, 16'h0000, 1'b1, 16'hA5C3, 1'b0);

        // no preamble, unshifted data
        write_register(CFG_PREAMBLE, 6'd0);
        write_register(CFG_READ_SHIFT, 6'd0);
        run_frame(OP_READ, 5'd0, 5'd0, 16'hFFFF, 1'b1, 16'h8001, 1'b1);
        run_frame(OP_READ, 5'd21, 5'd10, 16'h0000, 1'b0, 16'hFFFF, 1'b0);

        // preamble beyond the maximum saturates
        write_register(CFG_PREAMBLE, 6'd63);
        write_register(CFG_READ_SHIFT, 6'd1);
        run_frame(OP_WRITE, 5'd5, 5'd17, 16'h5A5A, 1'b1, 16'h0000, 1'b1);

        while (items_sent < 450) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                write_register(CFG_PREAMBLE, ($urandom_range(0, 9) < 7)
                               ? 6'($urandom_range(0, 6)) : 6'($urandom_range(0, 63)));
                write_register(CFG_READ_SHIFT, 6'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 9) < 2) begin
                idle_ticks($urandom_range(1, 6));
            end else begin
                run_frame($urandom_range(0, 1) ? OP_READ : OP_WRITE,
                          5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                          16'($urandom_range(0, 65535)), $urandom_range(0, 7) != 0,
                          16'($urandom_range(0, 65535)), $urandom_range(0, 2) == 0);
            end
        end

        no_idle = 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_lines.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
